// File: hdl/subset_sum_unique_solver_assert.svh
// ----------------------------------------------------------------------------
// Subset-sum solver assertion macros
// Shared assertion wrappers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBSET_SUM_UNIQUE_SOLVER_ASSERT_SVH
`define SUBSET_SUM_UNIQUE_SOLVER_ASSERT_SVH

// Same-cycle implication.
`define SSU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared widths, codes and queue types of the subset-sum solver.
// ----------------------------------------------------------------------------
package ssu_pkg;

    localparam int WEIGHT_W    = 12;
    localparam int TARGET_W    = 12;
    localparam int NUM_W       = 7;   // item numbers and counts, up to 64
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    // Status codes; also the saturated way-count values.
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MULTI  = 2'd2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NUM_W-1:0]    item_num;  // one-based row number when kept
        logic [NUM_W-1:0]    set_size;  // items stored so far, used on last
        logic                keep;
        logic                last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_xfer_t;

endpackage

// File: hdl/ssu_front.sv
// ----------------------------------------------------------------------------
// ssu_front
// Accepts items, numbers them and flags those beyond the row capacity.
// ----------------------------------------------------------------------------
module ssu_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssu_pkg::WEIGHT_W-1:0]  item_weight,
    input  logic                          last_item,
    input  logic                          q_full,
    output ssu_pkg::q_xfer_t              push
);

    logic [ssu_pkg::NUM_W-1:0] count_reg;
    logic [ssu_pkg::NUM_W-1:0] count_next;
    logic [ssu_pkg::NUM_W-1:0] count_inc;
    logic                      accept;
    logic                      keep;

    assign accept    = start && !q_full;
    assign keep      = count_reg < ssu_pkg::NUM_W'(MAX_ITEMS);
    assign count_inc = count_reg + ssu_pkg::NUM_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (last_item)
                count_next = '0;
            else if (keep)
                count_next = count_inc;
        end
    end

    always_comb
    begin
        push.valid          = accept;
        push.entry.weight   = item_weight;
        push.entry.item_num = count_inc;
        push.entry.set_size = keep ? count_inc : count_reg;
        push.entry.keep     = keep;
        push.entry.last     = last_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: hdl/ssu_queue.sv
// ----------------------------------------------------------------------------
// ssu_queue
// Short queue between item intake and the row engine.
// ----------------------------------------------------------------------------
`include "subset_sum_unique_solver_assert.svh"

module ssu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  ssu_pkg::q_xfer_t push,
    output logic             full,
    output ssu_pkg::q_xfer_t pop,
    input  logic             pop_ready
);

    localparam int DEPTH = ssu_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ssu_pkg::q_entry_t slot_reg [0:DEPTH-1];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign pop.valid = count_reg != '0;
    assign pop.entry = slot_reg[rd_ptr_reg];
    assign do_push   = push.valid;
    assign do_pop    = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

    `SSU_ASSERT_NOW(a_q_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count over depth")
    `SSU_ASSERT_NOW(a_q_no_overflow, push.valid, !full, "push into full queue")
    `SSU_ASSERT_NEXT(a_q_push_visible, push.valid && (count_reg == '0), pop.valid,
        "pushed entry not visible")

endmodule

// File: hdl/ssu_back.sv
// ----------------------------------------------------------------------------
// ssu_back
// Row engine: builds count rows, reads the status, walks back, lists items.
// ----------------------------------------------------------------------------
`include "subset_sum_unique_solver_assert.svh"

module ssu_back #(
    parameter int MAX_ITEMS = 64,
    parameter int MAX_SUM   = 4095
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssu_pkg::q_xfer_t              pop,
    output logic                          pop_ready,
    input  logic [ssu_pkg::TARGET_W-1:0]  target_sum,
    output logic                          result_valid,
    output logic [ssu_pkg::STATUS_W-1:0]  status,
    output logic                          card_valid,
    output logic [ssu_pkg::NUM_W-1:0]     item_number,
    output logic                          run_end
);

    localparam int SW  = $clog2(MAX_SUM + 1);
    localparam int RW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int AW  = RW + SW;
    localparam int WW  = ssu_pkg::WEIGHT_W;
    localparam int NW  = ssu_pkg::NUM_W;
    localparam int XW  = ((SW > WW) ? SW : WW) + 1;
    localparam int STW = ssu_pkg::STATUS_W;
    localparam logic [SW-1:0] S_LAST = SW'(MAX_SUM);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_BUILD   = 9'b000000010,
        S_FLUSH   = 9'b000000100,
        S_STAT_RD = 9'b000001000,
        S_STAT    = 9'b000010000,
        S_WB_W    = 9'b000100000,
        S_WB_T    = 9'b001000000,
        S_WB_D    = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    // memories
    logic [STW-1:0] table_mem  [0:(2**AW)-1];
    logic [WW-1:0]  wstore_mem [0:MAX_ITEMS-1];

    state_t         state_reg, state_next;
    logic [SW-1:0]  s_reg, s_next;
    logic [WW-1:0]  weight_reg, weight_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           first_row_reg, first_row_next;
    logic           last_reg, last_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  i_reg, i_next;
    logic [NW-1:0]  j_reg, j_next;
    logic [NW-1:0]  left_reg, left_next;
    logic [SW-1:0]  rem_reg, rem_next;
    logic [MAX_ITEMS-1:0] used_reg, used_next;
    logic           wb_ge_reg, wb_ge_next;
    logic [SW-1:0]  wb_diff_reg, wb_diff_next;

    // build pipeline stage
    logic           p_valid_reg;
    logic [SW-1:0]  p_s_reg;
    logic           p_ge_reg;
    logic           p_szero_reg;
    logic           p_dzero_reg;

    // result register
    logic           res_valid_reg, res_valid_next;
    logic [STW-1:0] res_status_reg, res_status_next;
    logic           res_card_reg, res_card_next;
    logic [NW-1:0]  res_num_reg, res_num_next;
    logic           res_end_reg, res_end_next;

    // memory ports
    logic           rd_a_en, rd_b_en;
    logic [AW-1:0]  rd_a_addr, rd_b_addr;
    logic [STW-1:0] rd_a_reg, rd_b_reg;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [STW-1:0] wr_data;
    logic           ws_wr_en, ws_rd_en;
    logic [RW-1:0]  ws_wr_addr, ws_rd_addr;
    logic [WW-1:0]  wt_rd_reg;

    // helpers
    logic [XW-1:0]  build_diff;
    logic           build_ge;
    logic [XW-1:0]  walk_diff;
    logic [XW-1:0]  target_x;
    logic           target_in_range;
    logic [SW-1:0]  target_s;
    logic [RW-1:0]  prev_row;
    logic [NW-1:0]  i_m1;
    logic [NW-1:0]  i_m2;
    logic [STW-1:0] a_val, b_val;
    logic [STW:0]   ab_sum;
    logic [STW-1:0] stat_val;
    logic           wb_hit;

    assign build_diff      = XW'(s_reg) - XW'(weight_reg);
    assign build_ge        = ~build_diff[XW-1];
    assign walk_diff       = XW'(rem_reg) - XW'(wt_rd_reg);
    assign target_x        = XW'(target_sum);
    assign target_in_range = target_x <= XW'(MAX_SUM);
    assign target_s        = target_x[SW-1:0];
    assign prev_row        = row_reg - RW'(1);
    assign i_m1            = i_reg - NW'(1);
    assign i_m2            = i_reg - NW'(2);

    // second build stage: row 0 is implicit (one way to reach zero only)
    assign a_val   = first_row_reg ? {1'b0, p_szero_reg} : rd_a_reg;
    assign b_val   = !p_ge_reg ? '0 : (first_row_reg ? {1'b0, p_dzero_reg} : rd_b_reg);
    assign ab_sum  = {1'b0, a_val} + {1'b0, b_val};
    assign wr_en   = p_valid_reg;
    assign wr_addr = {row_reg, p_s_reg};
    assign wr_data = p_szero_reg ? ssu_pkg::STATUS_UNIQUE :
                     (ab_sum > (STW + 1)'(ssu_pkg::STATUS_MULTI)) ? ssu_pkg::STATUS_MULTI :
                     ab_sum[STW-1:0];

    assign stat_val = target_in_range ? rd_a_reg : ssu_pkg::STATUS_NONE;
    assign wb_hit   = wb_ge_reg &&
                      ((i_reg == NW'(1)) ? (wb_diff_reg == '0) : (rd_a_reg != '0));

    assign pop_ready  = state_reg == S_IDLE;
    assign ws_wr_addr = RW'(pop.entry.item_num - NW'(1));
    assign ws_rd_addr = RW'(i_m1);

    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        weight_next     = weight_reg;
        row_next        = row_reg;
        first_row_next  = first_row_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        left_next       = left_reg;
        rem_next        = rem_reg;
        used_next       = used_reg;
        wb_ge_next      = wb_ge_reg;
        wb_diff_next    = wb_diff_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_card_next   = res_card_reg;
        res_num_next    = res_num_reg;
        res_end_next    = res_end_reg;
        rd_a_en         = 1'b0;
        rd_b_en         = 1'b0;
        rd_a_addr       = {prev_row, s_reg};
        rd_b_addr       = {prev_row, build_diff[SW-1:0]};
        ws_wr_en        = 1'b0;
        ws_rd_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop.valid)
                begin
                    weight_next    = pop.entry.weight;
                    row_next       = RW'(pop.entry.item_num - NW'(1));
                    first_row_next = pop.entry.item_num == NW'(1);
                    last_next      = pop.entry.last;
                    n_next         = pop.entry.set_size;
                    s_next         = '0;
                    if (pop.entry.keep)
                    begin
                        ws_wr_en   = 1'b1;
                        state_next = S_BUILD;
                    end
                    else if (pop.entry.last)
                        state_next = S_STAT_RD;
                end
            end

            S_BUILD:
            begin
                rd_a_en = !first_row_reg;
                rd_b_en = !first_row_reg && build_ge;
                s_next  = s_reg + SW'(1);
                if (s_reg == S_LAST)
                    state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                state_next = last_reg ? S_STAT_RD : S_IDLE;
            end

            S_STAT_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = {RW'(n_reg - NW'(1)), target_s};
                state_next = S_STAT;
            end

            S_STAT:
            begin
                if (stat_val != ssu_pkg::STATUS_UNIQUE)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_val;
                    res_card_next   = 1'b0;
                    res_num_next    = '0;
                    res_end_next    = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    rem_next   = target_s;
                    i_next     = n_reg;
                    left_next  = n_reg;
                    j_next     = NW'(1);
                    used_next  = '0;
                    state_next = (target_s == '0) ? S_EMIT : S_WB_W;
                end
            end

            S_WB_W:
            begin
                ws_rd_en   = 1'b1;
                state_next = S_WB_T;
            end

            S_WB_T:
            begin
                rd_a_en      = i_reg != NW'(1);
                rd_a_addr    = {RW'(i_m2), walk_diff[SW-1:0]};
                wb_ge_next   = ~walk_diff[XW-1];
                wb_diff_next = walk_diff[SW-1:0];
                state_next   = S_WB_D;
            end

            S_WB_D:
            begin
                if (wb_hit)
                begin
                    used_next[RW'(i_m1)] = 1'b1;
                    rem_next             = wb_diff_reg;
                    left_next            = left_reg - NW'(1);
                end
                i_next = i_m1;
                if ((i_reg == NW'(1)) || (wb_hit && (wb_diff_reg == '0)))
                    state_next = S_EMIT;
                else
                    state_next = S_WB_W;
            end

            S_EMIT:
            begin
                if (left_reg == '0)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ssu_pkg::STATUS_UNIQUE;
                    res_card_next   = 1'b0;
                    res_num_next    = '0;
                    res_end_next    = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    if (!used_reg[0])
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ssu_pkg::STATUS_UNIQUE;
                        res_card_next   = 1'b1;
                        res_num_next    = j_reg;
                        res_end_next    = left_reg == NW'(1);
                        left_next       = left_reg - NW'(1);
                        if (left_reg == NW'(1))
                            state_next = S_IDLE;
                    end
                    used_next = used_reg >> 1;
                    j_next    = j_reg + NW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_valid_reg   <= state_reg == S_BUILD;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        weight_reg     <= weight_next;
        row_reg        <= row_next;
        first_row_reg  <= first_row_next;
        last_reg       <= last_next;
        n_reg          <= n_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        left_reg       <= left_next;
        rem_reg        <= rem_next;
        used_reg       <= used_next;
        wb_ge_reg      <= wb_ge_next;
        wb_diff_reg    <= wb_diff_next;
        p_s_reg        <= s_reg;
        p_ge_reg       <= build_ge;
        p_szero_reg    <= s_reg == '0;
        p_dzero_reg    <= build_ge && (build_diff[SW-1:0] == '0);
        res_status_reg <= res_status_next;
        res_card_reg   <= res_card_next;
        res_num_reg    <= res_num_next;
        res_end_reg    <= res_end_next;
    end

    // way-count table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        if (rd_a_en)
            rd_a_reg <= table_mem[rd_a_addr];
        if (rd_b_en)
            rd_b_reg <= table_mem[rd_b_addr];
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (ws_wr_en)
            wstore_mem[ws_wr_addr] <= pop.entry.weight;
        if (ws_rd_en)
            wt_rd_reg <= wstore_mem[ws_rd_addr];
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign card_valid   = res_card_reg;
    assign item_number  = res_num_reg;
    assign run_end      = res_end_reg;

    `SSU_ASSERT_NOW(a_tbl_wr_in_build, wr_en,
        (state_reg == S_BUILD) || (state_reg == S_FLUSH), "table write outside row build")
    `SSU_ASSERT_NOW(a_card_is_unique, res_valid_reg && res_card_reg,
        res_status_reg == ssu_pkg::STATUS_UNIQUE, "listed item without unique status")
    `SSU_ASSERT_NEXT(a_gap_after_end, res_valid_reg && res_end_reg, !res_valid_reg,
        "result right after end of answer")

endmodule

// File: hdl/subset_sum_unique_solver.sv
// ----------------------------------------------------------------------------
// subset_sum_unique_solver
// Subset-sum uniqueness solver with saturating way counts (top level).
// ----------------------------------------------------------------------------
// Usage:
//   Items: drive item_weight/last_item with start; the transaction happens
//   on a clock edge with start high and busy low. Items are numbered from
//   one in arrival order; last_item closes the set and starts the answer.
//   Config: target_sum is written over cfg_valid/cfg_ready/cfg_data
//   (cfg_ready is always high); write it only while the block is idle.
//   Results: one transaction per cycle with result_valid high, fields
//   status/card_valid/item_number/run_end; the receiver cannot stall, so
//   results are simply presented for one cycle each.
// Timing:
//   Each stored item builds one table entry per cycle from the previous
//   row (one write, two reads of the count memory), then a pipeline
//   flush and a dispatch step follow. A two-entry queue lets intake run
//   ahead; busy rises while the queue is full. After the last row the status
//   is registered; a unique answer walks back row by row (read weight,
//   read table, decide) and lists at most one item per cycle.
// Reset: asynchronous, active low; the set is emptied, target_sum = 1.
//   The memories need no clearing: rows are rebuilt before being read.
// ----------------------------------------------------------------------------
module subset_sum_unique_solver #(
    parameter int MAX_ITEMS = 64,
    parameter int MAX_SUM   = 4095
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [ssu_pkg::WEIGHT_W-1:0]  item_weight,
    input  logic                          last_item,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssu_pkg::TARGET_W-1:0]  cfg_data,
    // result channel
    output logic                          result_valid,
    output logic [ssu_pkg::STATUS_W-1:0]  status,
    output logic                          card_valid,
    output logic [ssu_pkg::NUM_W-1:0]     item_number,
    output logic                          run_end
);

    // Target register; only read when a set closes.
    logic [ssu_pkg::TARGET_W-1:0] target_sum_reg;
    logic [ssu_pkg::TARGET_W-1:0] target_sum_next;

    ssu_pkg::q_xfer_t push;
    ssu_pkg::q_xfer_t pop;
    logic             q_full;
    logic             pop_ready;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;

    always_comb
    begin
        target_sum_next = target_sum_reg;
        if (cfg_valid && cfg_ready)
            target_sum_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_sum_reg <= ssu_pkg::TARGET_W'(1);
        else
            target_sum_reg <= target_sum_next;
    end

    // Intake: numbers items and marks those past the row capacity as dropped.
    ssu_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item_weight (item_weight),
        .last_item   (last_item),
        .q_full      (q_full),
        .push        (push)
    );

    // Decoupling queue.
    ssu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    // Row engine and answer sequencer.
    ssu_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_SUM   (MAX_SUM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_ready    (pop_ready),
        .target_sum   (target_sum_reg),
        .result_valid (result_valid),
        .status       (status),
        .card_valid   (card_valid),
        .item_number  (item_number),
        .run_end      (run_end)
    );

endmodule

// File: test/subset_sum_unique_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subset_sum_unique_solver testbench
// Streams weight sets through the solver and checks every answer against an
// in-bench count-table solver. The answer is the status plus the left-out
// item numbers. Covers directed corner sets, several target settings, one
// set that overflows the item store, and random sets.
// ----------------------------------------------------------------------------
module subset_sum_unique_solver_tb;

    localparam int MAX_ITEMS     = 64;
    localparam int MAX_SUM       = 4095;
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 64;     // answer is done long before this
    localparam int MAX_GAP       = 10;
    localparam int RANDOM_ITEMS  = 90;
    localparam int MAX_REPORTS   = 10;
    // Worst case is roughly 225 items plus answers, about 19 ms at 20 ns;
    // allow about five times that.
    localparam longint TIMEOUT_NS = 100_000_000;

    typedef logic [ssu_pkg::WEIGHT_W-1:0] weight_t;

    // One result transaction as seen on the result ports.
    typedef struct packed {
        logic [ssu_pkg::STATUS_W-1:0] status;
        logic                         card;
        logic [ssu_pkg::NUM_W-1:0]    num;
        logic                         fin;
    } answer_t;

    // Flavors of random set.
    typedef enum int {
        SET_UNIQUE_BUILT,   // target split over a few items, filler above target
        SET_SMALL,          // tiny weights, zero included: mostly ambiguous
        SET_NOISE           // full-range weights: mostly unreachable
    } set_kind_t;

    // ------------------------------------------------------------------------
    // Solution board: keeps its own count table and predicts each answer.
    // ------------------------------------------------------------------------
    class solution_board;
        weight_t     target;
        int unsigned loaded;
        weight_t     weights [1:MAX_ITEMS];
        bit [1:0]    ways [0:MAX_ITEMS][0:MAX_SUM];
        answer_t     awaited_results [$];
        int unsigned items_taken;
        int unsigned sets_closed;
        int unsigned results_checked;
        int unsigned mismatches;
        int unsigned status_tally [0:2];

        function new();
            target          = 1;
            loaded          = 0;
            items_taken     = 0;
            sets_closed     = 0;
            results_checked = 0;
            mismatches      = 0;
            for (int i = 0; i <= 2; i++)
                status_tally[i] = 0;
            for (int s = 0; s <= MAX_SUM; s++)
                ways[0][s] = 0;
            ways[0][0] = 1;
        endfunction

        // Append one expected result transaction.
        function void queue_answer(answer_t a);
            awaited_results.insert(awaited_results.size(), a);
        endfunction

        // Row r from row r-1, counts saturated at two.
        function void extend_row(int row, weight_t w);
            int c;
            ways[row][0] = 1;
            for (int s = 1; s <= MAX_SUM; s++) begin
                c = ways[row-1][s];
                if (s >= w)
                    c += ways[row-1][s - w];
                ways[row][s] = (c > ssu_pkg::STATUS_MULTI) ? ssu_pkg::STATUS_MULTI : c[1:0];
            end
        endfunction

        // Accepted item: extend the table; on the last one, queue the answer.
        function void note_item(weight_t w, logic lst);
            int                           n;
            int                           rem;
            int                           k;
            logic [ssu_pkg::STATUS_W-1:0] st;
            bit                           used [1:MAX_ITEMS];
            items_taken++;
            // Items past the store depth are dropped, last flag still counts.
            if (loaded < MAX_ITEMS) begin
                loaded++;
                weights[loaded] = w;
                extend_row(loaded, w);
            end
            if (!lst)
                return;
            n = loaded;
            loaded = 0;
            sets_closed++;
            st = ways[n][target];
            status_tally[st]++;
            if (st != ssu_pkg::STATUS_UNIQUE) begin
                queue_answer(answer_t'{st, 1'b0, '0, 1'b1});
                return;
            end
            // Walk back from the target: take item i if the rest is still
            // reachable with the items before it.
            for (int i = 1; i <= MAX_ITEMS; i++)
                used[i] = 0;
            rem = target;
            for (int i = n; i >= 1 && rem > 0; i--) begin
                if (rem >= weights[i] && ways[i-1][rem - weights[i]] != 0) begin
                    used[i] = 1;
                    rem -= weights[i];
                end
            end
            k = 0;
            for (int i = 1; i <= n; i++) begin
                if (!used[i]) begin
                    queue_answer(answer_t'{ssu_pkg::STATUS_UNIQUE, 1'b1,
                                           i[ssu_pkg::NUM_W-1:0], 1'b0});
                    k++;
                end
            end
            // Every item used: one empty card closes the answer.
            if (k == 0)
                queue_answer(answer_t'{ssu_pkg::STATUS_UNIQUE, 1'b0, '0, 1'b1});
            else
                awaited_results[$].fin = 1'b1;
        endfunction

        // Result transaction against the oldest expectation.
        function void check_result(answer_t got);
            answer_t want;
            results_checked++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d card %0b item %0d end %0b",
                             got.status, got.card, got.num, got.fin);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.card !== want.card ||
                got.num !== want.num || got.fin !== want.fin) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d mismatch: expected status %0d card %0b ",
                              "item %0d end %0b, got status %0d card %0b item %0d end %0b"},
                             results_checked, want.status, want.card, want.num,
                             want.fin, got.status, got.card, got.num, got.fin);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         start       = 1'b0;
    logic                         busy;
    weight_t                      item_weight = '0;
    logic                         last_item   = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    weight_t                      cfg_data    = '0;
    logic                         result_valid;
    logic [ssu_pkg::STATUS_W-1:0] status;
    logic                         card_valid;
    logic [ssu_pkg::NUM_W-1:0]    item_number;
    logic                         run_end;

    solution_board board = new();
    int unsigned   target_writes = 0;

    subset_sum_unique_solver #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_SUM   (MAX_SUM)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item_weight  (item_weight),
        .last_item    (last_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .card_valid   (card_valid),
        .item_number  (item_number),
        .run_end      (run_end)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Results cannot be stalled: take each one on the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(answer_t'{status, card_valid, item_number, run_end});
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One item transaction. With gap 0 start stays high so the next item can
    // follow back to back; whoever stops sending drops it.
    task automatic send_item(weight_t w, logic lst, int gap);
        start       <= 1'b1;
        item_weight <= w;
        last_item   <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(w, lst);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_set(weight_t ws[$], bit gaps_on);
        for (int i = 0; i < ws.size(); i++)
            send_item(ws[i], i == ws.size() - 1, gaps_on ? $urandom_range(0, MAX_GAP) : 0);
    endtask

    // Stop sending, let every awaited result arrive, then let the block settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(weight_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.target = v;
        target_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Random set of n items for the current target.
    function automatic void build_set(ref weight_t ws[$], input int n,
                                      input set_kind_t kind, input weight_t tgt);
        int      parts;
        int      rest;
        int      cut;
        int      j;
        weight_t tmp;
        ws.delete();
        case (kind)
            SET_SMALL:
                repeat (n) ws.insert(ws.size(), weight_t'($urandom_range(0, 15)));
            SET_NOISE:
                repeat (n) ws.insert(ws.size(), weight_t'($urandom_range(0, MAX_SUM)));
            default:
            begin
                // Split the target over a few items; filler above the target
                // cannot join any subset, so the answer is unique, unless the target is MAX_SUM.
                parts = (tgt == 0) ? 0 : $urandom_range(1, 4);
                if (parts > n)
                    parts = n;
                if (parts > tgt)
                    parts = tgt;
                rest = int'(tgt);
                for (int p = 0; p < parts; p++) begin
                    cut = (p == parts - 1) ? rest : $urandom_range(1, rest - (parts - 1 - p));
                    ws.insert(ws.size(), weight_t'(cut));
                    rest -= cut;
                end
                while (ws.size() < n)
                    ws.insert(ws.size(),
                              weight_t'(tgt < MAX_SUM ? $urandom_range(tgt + 1, MAX_SUM)
                                                      : $urandom_range(1, MAX_SUM)));
                for (int i = n - 1; i > 0; i--) begin
                    j     = $urandom_range(0, i);
                    tmp   = ws[i];
                    ws[i] = ws[j];
                    ws[j] = tmp;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        weight_t     ws[$];
        weight_t     tgt;
        int          n;
        set_kind_t   kind;
        int unsigned random_from;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset target of one: single item of weight one, nothing left out.
        send_set('{12'd1}, 1'b0);

        // All-ones target: exact hit, two ways, and a hit leaving item 3 out.
        wait_drained();
        write_target(12'd4095);
        send_set('{12'd4095}, 1'b1);
        send_set('{12'd4095, 12'd4095}, 1'b0);
        send_set('{12'd4094, 12'd1, 12'd2048}, 1'b1);

        // Target zero: empty subset, every item listed (zero weight too).
        wait_drained();
        write_target(12'd0);
        send_set('{12'd5, 12'd0, 12'd4095}, 1'b0);

        // Zero weight doubles the counts: ambiguous; then an unreachable set.
        wait_drained();
        write_target(12'd1);
        send_set('{12'd1, 12'd0}, 1'b1);
        send_set('{12'd0, 12'd2, 12'd3}, 1'b0);

        // Unique pair out of four, items 2 and 4 left out.
        wait_drained();
        write_target(12'd10);
        send_set('{12'd3, 12'd20, 12'd7, 12'd1}, 1'b1);

        // Random phases: new target after a full drain, then a few sets.
        random_from = board.items_taken;
        for (int phase = 0; board.items_taken - random_from < RANDOM_ITEMS; phase++) begin
            wait_drained();
            tgt = weight_t'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                        : $urandom_range(1, MAX_SUM));
            write_target(tgt);
            // Once: a full store plus two items that must be dropped.
            if (phase == 1) begin
                build_set(ws, MAX_ITEMS, SET_UNIQUE_BUILT, tgt);
                repeat (2) ws.insert(ws.size(), weight_t'($urandom_range(0, MAX_SUM)));
                send_set(ws, $urandom_range(0, 1) == 1);
            end
            repeat ($urandom_range(3, 6)) begin
                n = $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0, 1:    kind = SET_SMALL;
                    2, 3:    kind = SET_NOISE;
                    default: kind = SET_UNIQUE_BUILT;
                endcase
                build_set(ws, n, kind, tgt);
                // Now and then hold off until the pipeline is empty.
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
                send_set(ws, $urandom_range(0, 1) == 1);
            end
        end

        wait_drained();
        $display("coverage: %0d items in %0d sets under %0d target writes, incl. an overfull set",
                 board.items_taken, board.sets_closed, target_writes);
        $display("answers: %0d unique, %0d ambiguous, %0d unreachable; %0d results, %0d bad",
                 board.status_tally[ssu_pkg::STATUS_UNIQUE],
                 board.status_tally[ssu_pkg::STATUS_MULTI],
                 board.status_tally[ssu_pkg::STATUS_NONE],
                 board.results_checked, board.mismatches);
        if (board.mismatches == 0 && board.awaited_results.size() == 0)
            $display("subset_sum_unique_solver_tb: done, clean");
        else
            $display("subset_sum_unique_solver_tb: done, errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("subset_sum_unique_solver_tb: done, errors");
        $finish;
    end

endmodule
